FILE: design/positional_list_engine_macros.svh
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define PLE_ASSERT_HOLD(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define PLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Operation codes and the command and status bundles between the modules.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY_DEFAULT = 1024;
  localparam int DATA_W           = 32;
  localparam int FUNC_W           = 3;

  localparam logic [FUNC_W-1:0] FUNC_LENGTH = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_MOVE   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_MAX    = 3'd5;

  typedef enum logic [1:0] {
    RD_POS,
    RD_SHIFT,
    RD_IDX
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_SHIFT,
    WR_VAL,
    WR_MOVED
  } wr_sel_e;

  typedef enum logic [1:0] {
    RES_COUNT,
    RES_NEG1,
    RES_RDATA,
    RES_MAX
  } res_sel_e;

  typedef struct packed {
    logic     capture;
    logic     idx_init;
    logic     idx_step;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wr_sel_e  wr_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     moved_load;
    logic     max_cmp;
    logic     res_load;
    res_sel_e res_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
    logic              pos_le_n;
    logic              pos_lt_n;
    logic              shift_done;
    logic              idx_last;
    logic              out_free;
  } dp_status_t;

endpackage

FILE: design/ple_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ple_datapath.sv
// ----------------------------------------------------------------------------
// Positional list engine datapath
// Item registers, length, walking index, element RAM, maximum and output stage.
// ----------------------------------------------------------------------------
`include "positional_list_engine_macros.svh"

module ple_datapath #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ple_pkg::FUNC_W-1:0] func_i,
  input  logic [ple_pkg::DATA_W-1:0] position_i,
  input  logic [ple_pkg::DATA_W-1:0] value_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [ple_pkg::DATA_W-1:0] out_data_o,
  input  ple_pkg::dp_cmd_t           cmd_i,
  output ple_pkg::dp_status_t        status_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = ple_pkg::DATA_W;

  logic [ple_pkg::FUNC_W-1:0] func_q;
  logic [DW-1:0]              pos_q, val_q, moved_q, best_q, res_q, out_data_q;
  logic [CW-1:0]              count_q, count_d;
  logic [AW-1:0]              idx_q, idx_d, idx_init, raddr, rdaddr_shift;
  logic                       out_valid_q, out_valid_d;
  logic [DW-1:0]              rdata, wdata, best_d, res_d;
  logic [DW-1:0]              count_w, idx_w;
  logic                       is_insert;

  assign is_insert = (func_q == ple_pkg::FUNC_INSERT);
  assign count_w   = DW'(count_q);
  assign idx_w     = DW'(idx_q);

  // Insert starts at the current end (zero in an empty list), max at the head,
  // remove and move at the requested position.
  always_comb begin
    if (is_insert) begin
      idx_init = AW'(count_q);
    end else if (func_q == ple_pkg::FUNC_MAX) begin
      idx_init = '0;
    end else begin
      idx_init = pos_q[AW-1:0];
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_init) begin
      idx_d = idx_init;
    end else if (cmd_i.idx_step) begin
      idx_d = is_insert ? idx_q - AW'(1) : idx_q + AW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  assign rdaddr_shift = is_insert ? idx_q - AW'(1) : idx_q + AW'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      ple_pkg::RD_POS:   raddr = pos_q[AW-1:0];
      ple_pkg::RD_SHIFT: raddr = rdaddr_shift;
      default:           raddr = idx_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      ple_pkg::WR_VAL:   wdata = val_q;
      ple_pkg::WR_MOVED: wdata = moved_q;
      default:           wdata = rdata;
    endcase
  end

  assign best_d = ((idx_q == '0) || ($signed(rdata) > $signed(best_q))) ? rdata : best_q;

  always_comb begin
    case (cmd_i.res_sel)
      ple_pkg::RES_COUNT: res_d = count_w;
      ple_pkg::RES_NEG1:  res_d = '1;
      ple_pkg::RES_RDATA: res_d = rdata;
      default:            res_d = best_d;
    endcase
  end

  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  ple_ram #(
    .WIDTH(DW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(idx_q),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      pos_q  <= position_i;
      val_q  <= value_i;
    end
    idx_q <= idx_d;
    if (cmd_i.moved_load) begin
      moved_q <= rdata;
    end
    if (cmd_i.max_cmp) begin
      best_q <= best_d;
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_data_q <= res_q;
    end
  end

  always_comb begin
    status_o.func     = func_q;
    status_o.full     = (count_q == CW'(CAPACITY));
    status_o.empty    = (count_q == '0);
    status_o.pos_le_n = (pos_q <= count_w);
    status_o.pos_lt_n = (pos_q < count_w);
    status_o.idx_last = ((idx_w + DW'(1)) == count_w);
    if (is_insert) begin
      status_o.shift_done = (idx_q == pos_q[AW-1:0]) || (count_q == '0);
    end else begin
      status_o.shift_done = ((idx_w + DW'(1)) >= count_w);
    end
    status_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `PLE_ASSERT_HOLD(a_count_bound, count_q <= CW'(CAPACITY), "length exceeds capacity")
  `PLE_ASSERT_IMPL(a_out_free, cmd_i.out_load, !out_valid_q || out_ready_i,
                   "result loaded over a pending result")
  `PLE_ASSERT_IMPL(a_no_overfill, cmd_i.cnt_inc, count_q < CW'(CAPACITY),
                   "insert grew a full list")
  `PLE_ASSERT_IMPL(a_no_underflow, cmd_i.cnt_dec, count_q != '0,
                   "remove shrank an empty list")

endmodule

FILE: design/ple_controller.sv
// ----------------------------------------------------------------------------
// Positional list engine controller
// Sequences decode, element shifts, reads, maximum scan and result hand-off.
// ----------------------------------------------------------------------------
module ple_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ple_pkg::dp_status_t status_i,
  output ple_pkg::dp_cmd_t    cmd_o
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DECODE   = 4'd1;
  localparam logic [3:0] ST_SHIFT    = 4'd2;
  localparam logic [3:0] ST_SH_WR    = 4'd3;
  localparam logic [3:0] ST_MV_LATCH = 4'd4;
  localparam logic [3:0] ST_Q_DATA   = 4'd5;
  localparam logic [3:0] ST_MX_RD    = 4'd6;
  localparam logic [3:0] ST_MX_CMP   = 4'd7;
  localparam logic [3:0] ST_EMIT     = 4'd8;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel  = ple_pkg::RD_IDX;
    cmd_o.wr_sel  = ple_pkg::WR_SHIFT;
    cmd_o.res_sel = ple_pkg::RES_NEG1;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status_i.func)
          ple_pkg::FUNC_LENGTH: begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = ple_pkg::RES_COUNT;
            state_d        = ST_EMIT;
          end
          ple_pkg::FUNC_INSERT: begin
            if (status_i.full || (!status_i.empty && !status_i.pos_le_n)) begin
              state_d = ST_IDLE;
            end else begin
              cmd_o.idx_init = 1'b1;
              state_d        = ST_SHIFT;
            end
          end
          ple_pkg::FUNC_QUERY: begin
            if (status_i.pos_lt_n) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = ple_pkg::RD_POS;
              state_d      = ST_Q_DATA;
            end else begin
              cmd_o.res_load = 1'b1;
              state_d        = ST_EMIT;
            end
          end
          ple_pkg::FUNC_REMOVE: begin
            if (status_i.pos_lt_n) begin
              cmd_o.idx_init = 1'b1;
              state_d        = ST_SHIFT;
            end else begin
              state_d = ST_IDLE;
            end
          end
          ple_pkg::FUNC_MOVE: begin
            if (status_i.pos_lt_n) begin
              cmd_o.idx_init = 1'b1;
              cmd_o.rd_en    = 1'b1;
              cmd_o.rd_sel   = ple_pkg::RD_POS;
              state_d        = ST_MV_LATCH;
            end else begin
              state_d = ST_IDLE;
            end
          end
          ple_pkg::FUNC_MAX: begin
            if (status_i.empty) begin
              cmd_o.res_load = 1'b1;
              state_d        = ST_EMIT;
            end else begin
              cmd_o.idx_init = 1'b1;
              state_d        = ST_MX_RD;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_MV_LATCH: begin
        cmd_o.moved_load = 1'b1;
        state_d          = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (status_i.shift_done) begin
          // The walk has reached its end; finish the operation in place.
          state_d = ST_IDLE;
          case (status_i.func)
            ple_pkg::FUNC_INSERT: begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_sel  = ple_pkg::WR_VAL;
              cmd_o.cnt_inc = 1'b1;
            end
            ple_pkg::FUNC_MOVE: begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wr_sel = ple_pkg::WR_MOVED;
            end
            default: begin
              cmd_o.cnt_dec = 1'b1;
            end
          endcase
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ple_pkg::RD_SHIFT;
          state_d      = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = ple_pkg::WR_SHIFT;
        cmd_o.idx_step = 1'b1;
        state_d        = ST_SHIFT;
      end
      ST_Q_DATA: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = ple_pkg::RES_RDATA;
        state_d        = ST_EMIT;
      end
      ST_MX_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ple_pkg::RD_IDX;
        state_d      = ST_MX_CMP;
      end
      ST_MX_CMP: begin
        cmd_o.max_cmp = 1'b1;
        if (status_i.idx_last) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = ple_pkg::RES_MAX;
          state_d        = ST_EMIT;
        end else begin
          cmd_o.idx_step = 1'b1;
          state_d        = ST_MX_RD;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/positional_list_engine.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed words with insert, remove, move, query and maximum.
// ----------------------------------------------------------------------------
// The block keeps an ordered list of up to CAPACITY signed 32-bit words in a
// single RAM with one write port and one registered read port, plus a length
// register that reset clears; the RAM itself is not cleared and needs no
// clearing pass. One item is worked at a time. Every element that moves is
// read from that RAM and then written back one place over, so insert and
// remove walk the shifted elements one by one, move first latches the chosen
// element and writes it at the end after the walk, and max reads each element
// in turn; length and query need no walk. A result waits in an output
// register, and the next item is taken while it does; only a following
// result item stalls until the previous one has been taken.
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: position [31:0], value [63:32].
  input  logic [63:0] s_axis_tdata,
  // Fields from bit 0: func [2:0].
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: result_value [31:0].
  output logic [31:0] m_axis_tdata
);

  ple_pkg::dp_cmd_t    cmd;
  ple_pkg::dp_status_t status;

  // The controller decides every step; the datapath owns all storage.
  ple_controller u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  ple_datapath #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .func_i     (s_axis_tuser),
    .position_i (s_axis_tdata[31:0]),
    .value_i    (s_axis_tdata[63:32]),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

FILE: dv/positional_list_engine_tb.sv
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Self-checking stream test of length, insert, query, remove, move and max.
// ----------------------------------------------------------------------------
// A short table of directed requests comes first: the empty list, refused
// positions, the extreme values and the unused selectors. Random requests
// follow, with the list length held in changing bands. A final stretch
// runs without any idling. Every accepted request goes through a behavioral
// copy of the list, and each result is compared in order with what that copy
// predicts. Random idle bursts on both stream sides move the gaps across every
// phase of the element walks.
module positional_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int unsigned LIST_CAPACITY = CAPACITY_DEFAULT;

  // Selector codes that the block must ignore.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  localparam logic [31:0] NEG_ONE = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_NEG = 32'h8000_0000;

  // The longest single request is a max or a shift over a full list, plus an
  // output stall. The limits sit well above it.
  localparam int unsigned SETTLE_CYCLES  = 2 * LIST_CAPACITY + 16;
  localparam int unsigned WATCHDOG_LIMIT = 8 * LIST_CAPACITY + 1000;
  localparam int unsigned RANDOM_ITEMS   = 460;
  localparam int unsigned QUIET_ITEMS    = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // Fields from bit 0: position [31:0], value [63:32].
  logic [63:0] s_axis_tdata = '0;
  // Fields from bit 0: func [2:0].
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // Fields from bit 0: result_value [31:0].
  logic [31:0] m_axis_tdata;

  positional_list_engine #(
    .CAPACITY(LIST_CAPACITY)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Behavioral copy of the list and the values it says must come out.
  logic [31:0] list_store [LIST_CAPACITY];
  int unsigned list_len;
  logic [31:0] pending_results [$];

  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned refused_count;
  int unsigned full_refusals;
  int unsigned peak_len;
  int unsigned idle_cycles;
  bit          ready_idling = 1'b1;
  int unsigned ready_hold;

  // One row of the directed table. Rows with fixed set carry a result that
  // is obvious from the list contents; the rest rely on the list copy.
  typedef struct packed {
    logic [FUNC_W-1:0] fn;
    logic [31:0]       pos;
    logic [31:0]       val;
    logic              fixed;
    logic [31:0]       want;
  } request_row_t;

  localparam int unsigned DIRECTED_ROWS = 27;
  localparam request_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    // Fresh out of reset the list is empty.
    '{FUNC_LENGTH, 32'd0, 32'd0, 1'b1, 32'd0},
    '{FUNC_MAX,    32'd0, 32'd0, 1'b1, NEG_ONE},
    '{FUNC_QUERY,  32'd0, 32'd0, 1'b1, NEG_ONE},
    '{FUNC_REMOVE, 32'd0, 32'd0, 1'b0, 32'd0},
    '{FUNC_MOVE,   32'd0, 32'd0, 1'b0, 32'd0},
    // An insert into an empty list lands at the head whatever the position.
    '{FUNC_INSERT, 32'd12345, MAX_POS, 1'b0, 32'd0},
    '{FUNC_QUERY,  32'd0, 32'd0, 1'b1, MAX_POS},
    // Negative position and position past the length are both refused.
    '{FUNC_INSERT, NEG_ONE, 32'd5, 1'b0, 32'd0},
    '{FUNC_INSERT, 32'd2,   32'd5, 1'b0, 32'd0},
    '{FUNC_LENGTH, 32'd0, 32'd0, 1'b1, 32'd1},
    // Append, head and middle inserts give [0, -1, max, min].
    '{FUNC_INSERT, 32'd1, MIN_NEG, 1'b0, 32'd0},
    '{FUNC_INSERT, 32'd0, 32'd0,   1'b0, 32'd0},
    '{FUNC_INSERT, 32'd1, NEG_ONE, 1'b0, 32'd0},
    '{FUNC_MAX,    32'd0, 32'd0, 1'b1, MAX_POS},
    // Queries at the length and at both position extremes are invalid.
    '{FUNC_QUERY,  32'd4,   32'd0, 1'b1, NEG_ONE},
    '{FUNC_QUERY,  MIN_NEG, 32'd0, 1'b1, NEG_ONE},
    '{FUNC_QUERY,  MAX_POS, 32'd0, 1'b1, NEG_ONE},
    // Moving the last element changes nothing; moving the head rotates.
    '{FUNC_MOVE,   32'd3, 32'd0, 1'b0, 32'd0},
    '{FUNC_MOVE,   32'd0, 32'd0, 1'b0, 32'd0},
    '{FUNC_REMOVE, 32'd4, 32'd0, 1'b0, 32'd0},
    '{FUNC_REMOVE, 32'hFFFF_FFFB, 32'd0, 1'b0, 32'd0},
    // Unused selectors with every data bit set are dropped silently.
    '{FUNC_SPARE_6, NEG_ONE, NEG_ONE, 1'b0, 32'd0},
    '{FUNC_SPARE_7, NEG_ONE, NEG_ONE, 1'b0, 32'd0},
    '{FUNC_REMOVE, 32'd1, 32'd0, 1'b0, 32'd0},
    '{FUNC_MAX,    32'd0, 32'd0, 1'b0, 32'd0},
    '{FUNC_QUERY,  32'd1, 32'd0, 1'b0, 32'd0},
    '{FUNC_LENGTH, 32'd0, 32'd0, 1'b1, 32'd3}
  };

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 20) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // Applies one request to the list copy. has_res tells whether the block
  // must answer, acted whether the request did anything at all.
  function automatic void apply_request(input logic [FUNC_W-1:0] fn,
                                        input logic [31:0] pos,
                                        input logic [31:0] val,
                                        output bit has_res,
                                        output logic [31:0] res,
                                        output bit acted);
    logic [31:0] moved;
    int unsigned k;
    has_res = 1'b0;
    res = '0;
    acted = 1'b0;
    case (fn)
      FUNC_LENGTH: begin
        has_res = 1'b1;
        res = list_len;
        acted = 1'b1;
      end
      FUNC_INSERT: begin
        if (list_len >= LIST_CAPACITY) begin
          full_refusals++;
        end else if (list_len == 0) begin
          list_store[0] = val;
          list_len = 1;
          acted = 1'b1;
        end else if (pos <= list_len) begin
          for (k = list_len; k > pos; k--) list_store[k] = list_store[k-1];
          list_store[pos] = val;
          list_len++;
          acted = 1'b1;
        end
      end
      FUNC_QUERY: begin
        has_res = 1'b1;
        res = (pos < list_len) ? list_store[pos] : NEG_ONE;
        acted = 1'b1;
      end
      FUNC_REMOVE: begin
        if (pos < list_len) begin
          for (k = pos; k + 1 < list_len; k++) list_store[k] = list_store[k+1];
          list_len--;
          acted = 1'b1;
        end
      end
      FUNC_MOVE: begin
        if (pos < list_len) begin
          moved = list_store[pos];
          for (k = pos; k + 1 < list_len; k++) list_store[k] = list_store[k+1];
          list_store[list_len-1] = moved;
          acted = 1'b1;
        end
      end
      FUNC_MAX: begin
        has_res = 1'b1;
        acted = 1'b1;
        if (list_len == 0) begin
          res = NEG_ONE;
        end else begin
          res = list_store[0];
          for (k = 1; k < list_len; k++) begin
            if ($signed(list_store[k]) > $signed(res)) res = list_store[k];
          end
        end
      end
      default: ;
    endcase
    if (list_len > peak_len) peak_len = list_len;
  endfunction

  // Presents one request and holds it until the block takes it. tvalid is
  // left high on return so that a back-to-back request keeps it asserted.
  task automatic send_request(input logic [FUNC_W-1:0] fn,
                              input logic [31:0] pos,
                              input logic [31:0] val,
                              input bit fixed,
                              input logic [31:0] want,
                              output bit acted);
    bit          has_res;
    logic [31:0] res;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {val, pos};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    apply_request(fn, pos, val, has_res, res, acted);
    if (!acted) refused_count++;
    if (has_res) pending_results.push_back(fixed ? want : res);
  endtask

  // Random idle burst on the sending side.
  task automatic sender_gap(input bit idle_on);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Holds the sender off until every predicted result has come out.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return MAX_POS;
      1:       return MIN_NEG;
      2:       return $urandom_range(0, 15) - 8;
      default: return $urandom();
    endcase
  endfunction

  // One random request. The length is steered into [lo, hi]; most positions
  // are valid so that the shifts do real work, the rest probe the edges and
  // the full 32-bit range.
  task automatic random_request(input int unsigned lo, input int unsigned hi,
                                input bit idle_on, output bit acted);
    logic [FUNC_W-1:0] fn;
    logic [31:0]       pos;
    int unsigned       n;
    int unsigned       r;
    int unsigned       ins_w;
    int unsigned       rem_w;
    n = list_len;
    ins_w = (n < lo) ? 70 : (n >= hi) ? 8 : 34;
    rem_w = (n >= hi) ? 40 : 12;
    r = $urandom_range(0, 99);
    if (r < ins_w) begin
      fn = FUNC_INSERT;
    end else if (r < ins_w + rem_w) begin
      fn = FUNC_REMOVE;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 30)      fn = FUNC_QUERY;
      else if (r < 50) fn = FUNC_MOVE;
      else if (r < 70) fn = FUNC_MAX;
      else if (r < 94) fn = FUNC_LENGTH;
      else if (r < 97) fn = FUNC_SPARE_6;
      else             fn = FUNC_SPARE_7;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      pos = $urandom();
    end else if (r < 16) begin
      case ($urandom_range(0, 3))
        0:       pos = n;
        1:       pos = n + 1;
        2:       pos = (n == 0) ? 0 : n - 1;
        default: pos = 0;
      endcase
    end else if (fn == FUNC_INSERT) begin
      pos = $urandom_range(0, n);
    end else begin
      pos = (n == 0) ? 0 : $urandom_range(0, n - 1);
    end
    send_request(fn, pos, pick_value(), 1'b0, '0, acted);
    if (idle_on && $urandom_range(0, 49) == 0) wait_results_drained();
    else sender_gap(idle_on);
  endtask

  // Receiver idling: random stall bursts while enabled.
  always @(posedge clk_i) begin
    if (!ready_idling) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      ready_hold <= $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Each accepted result is matched against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    logic [31:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected",
                                  $signed(m_axis_tdata)));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (m_axis_tdata !== want) begin
          report_mismatch($sformatf("result_value %0d, expected %0d",
                                    $signed(m_axis_tdata), $signed(want)));
        end
      end
    end
  end

  // Ends the run if neither side moves an item for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    bit          acted;
    bit          idle_on;
    int unsigned done;
    int unsigned lo;
    int unsigned hi;
    list_len = 0;
    peak_len = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_request(DIRECTED_TABLE[i].fn, DIRECTED_TABLE[i].pos, DIRECTED_TABLE[i].val,
                   DIRECTED_TABLE[i].fixed, DIRECTED_TABLE[i].want, acted);
      sender_gap(1'b1);
    end
    wait_results_drained();

    // Random part in segments of about a hundred items. Each segment holds
    // the length in its own band and turns idling on or off.
    done = 0;
    while (done < RANDOM_ITEMS) begin
      case ((done / 100) % 4)
        0:       begin lo = 0;  hi = 4;  end
        1:       begin lo = 8;  hi = 48; end
        2:       begin lo = 2;  hi = 16; end
        default: begin lo = 30; hi = 64; end
      endcase
      idle_on = ((done / 100) != 2);
      ready_idling <= idle_on;
      random_request(lo, hi, idle_on, acted);
      if (acted) done++;
    end
    ready_idling <= 1'b1;
    wait_results_drained();

    // Closing stretch at full rate on both sides.
    ready_idling <= 1'b0;
    done = 0;
    while (done < QUIET_ITEMS) begin
      random_request(0, 8, 1'b0, acted);
      if (acted) done++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("summary: %0d requests sent, %0d results checked, %0d requests refused",
             items_sent, results_checked, refused_count);
    $display("summary: peak length %0d of %0d, %0d inserts refused on a full list",
             peak_len, LIST_CAPACITY, full_refusals);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
